// File: sv/cloud_value_noise_pixel_assert.svh
// ----------------------------------------------------------------------------
// Cloud value noise pixel: assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CLOUD_VALUE_NOISE_PIXEL_ASSERT_SVH
`define CLOUD_VALUE_NOISE_PIXEL_ASSERT_SVH

// A condition that holds at every edge outside reset.
`define CVN_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A trigger that implies a condition at the same edge.
`define CVN_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A trigger that implies a condition at the next edge.
`define CVN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cvn_pkg.sv
// ----------------------------------------------------------------------------
// Cloud value noise package
// Shared codes, types and the cosine ease table.
// ----------------------------------------------------------------------------
package cvn_pkg;

   // Item function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_COVERAGE = 1'b0;
   localparam logic CSR_PHASE    = 1'b1;

   localparam logic [8:0] COVERAGE_RESET = 9'd192;
   localparam logic [7:0] PHASE_RESET    = 8'd0;

   // Stage enables handed to each octave level unit.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } lvl_en_type;

   // Pixel data that rides along the pipeline.
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] mask;
   } pix_type;

   typedef logic [7:0] ease_tab_type [256];

   // pi in Q48 and the Taylor series divisors (2k)(2k+1).
   localparam logic [63:0] PI_Q48 = 64'h3243F6A8885A3;
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

   // Entry n is 256 sin^2(n pi / 512), which equals 128 - 128 cos(n pi / 256).
   function automatic ease_tab_type build_ease();
      ease_tab_type      tab;
      logic [63:0]       th;
      logic [63:0]       th2;
      logic [63:0]       term;
      logic [63:0]       sq;
      logic [63:0]       v;
      logic signed [63:0] sum;
      for (int n = 0; n < 256; n++) begin
         th   = (64'(n) * PI_Q48) >> 27;
         th2  = (th * th) >> 30;
         term = th;
         sum  = $signed(th);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * th2) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
         end
         sq = $unsigned(sum) * $unsigned(sum);
         v  = (sq + (64'd1 << 36)) >> 52;
         if (v > 64'd255) begin
            v = 64'd255;
         end
         tab[n] = v[7:0];
      end
      return tab;
   endfunction

   localparam ease_tab_type EASE_ROM = build_ease();

endpackage

// File: sv/cvn_req_if.sv
// ----------------------------------------------------------------------------
// Cloud value noise request channel
// Valid/ready channel carrying map writes and pixel requests.
// ----------------------------------------------------------------------------
interface cvn_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       bank;
   logic [2:0] level;
   logic [7:0] entry_index;
   logic [7:0] entry_value;
   logic [7:0] pixel_x;
   logic [7:0] pixel_y;
   logic [7:0] mask_alpha;

   modport source (output valid, func, bank, level, entry_index, entry_value,
                   pixel_x, pixel_y, mask_alpha, input ready);
   modport sink   (input valid, func, bank, level, entry_index, entry_value,
                   pixel_x, pixel_y, mask_alpha, output ready);
endinterface

// File: sv/cvn_rsp_if.sv
// ----------------------------------------------------------------------------
// Cloud value noise response channel
// Valid/ready channel carrying one cloud alpha per pixel.
// ----------------------------------------------------------------------------
interface cvn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] alpha_out;
   logic [7:0] out_x;
   logic [7:0] out_y;

   modport source (output valid, alpha_out, out_x, out_y, input ready);
   modport sink   (input valid, alpha_out, out_x, out_y, output ready);
endinterface

// File: sv/cvn_ram.sv
// ----------------------------------------------------------------------------
// Cloud value noise RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/cvn_level.sv
// ----------------------------------------------------------------------------
// Cloud value noise octave level
// Map storage, bank blend and eased bilinear interpolation for one level.
// ----------------------------------------------------------------------------
module cvn_level #(
   parameter int LEVELS = 5,
   parameter int K      = 0
) (
   input  logic               clock,
   input  cvn_pkg::lvl_en_type en,
   input  logic [7:0]         phase,
   input  logic               wr_en,
   input  logic               wr_bank,
   input  logic [2:0]         wr_level,
   input  logic [7:0]         wr_index,
   input  logic [7:0]         wr_value,
   input  logic [7:0]         pix_x,
   input  logic [7:0]         pix_y,
   output logic [7:0]         level_val
);
   localparam int MS     = 9 - LEVELS;
   localparam int SHIFT  = LEVELS - 1 - K;
   localparam int RSHIFT = 8 - SHIFT;
   localparam int AW     = (2 * MS > 8) ? 8 : 2 * MS;
   localparam int DEPTH  = 1 << AW;

   logic [7:0]    x_sh;
   logic [7:0]    y_sh;
   logic [MS-1:0] xa;
   logic [MS-1:0] ya;
   logic [MS-1:0] xb;
   logic [MS-1:0] yb;
   logic [2*MS-1:0] full_addr [4];
   logic [AW-1:0]   rd_addr [4];
   logic [7:0]    xe;
   logic [7:0]    ye;
   logic [7:0]    rd_data [2][4];

   logic [7:0]  xf1_ff, yf1_ff, xf2_ff, yf2_ff, yf3_ff;
   logic [7:0]  m_ff [4];
   logic [7:0]  m_in [4];
   logic [15:0] top_ff, bot_ff;
   logic [16:0] top_in, bot_in;
   logic [24:0] mix_in;
   logic [7:0]  lv_ff;
   logic [8:0]  inv_phase;
   logic [8:0]  inv_xf;
   logic [8:0]  inv_yf;

   // Neighbor cell addresses, wrapping at the map edge.
   assign x_sh = pix_x >> SHIFT;
   assign y_sh = pix_y >> SHIFT;
   assign xa   = x_sh[MS-1:0];
   assign ya   = y_sh[MS-1:0];
   assign xb   = xa + MS'(1);
   assign yb   = ya + MS'(1);
   assign full_addr[0] = {ya, xa};
   assign full_addr[1] = {ya, xb};
   assign full_addr[2] = {yb, xa};
   assign full_addr[3] = {yb, xb};
   assign xe = pix_x << RSHIFT;
   assign ye = pix_y << RSHIFT;

   for (genvar q = 0; q < 4; q++) begin : g_addr
      assign rd_addr[q] = full_addr[q][AW-1:0];
   end

   // Four copies per bank so that all neighbors read in the same cycle.
   for (genvar b = 0; b < 2; b++) begin : g_bank
      for (genvar q = 0; q < 4; q++) begin : g_copy
         cvn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
            .clock   (clock),
            .wr_en   (wr_en && (wr_bank == 1'(b)) && (wr_level == 3'(K))),
            .wr_addr (wr_index[AW-1:0]),
            .wr_data (wr_value),
            .rd_en   (en.s1),
            .rd_addr (rd_addr[q]),
            .rd_data (rd_data[b][q])
         );
      end
   end

   assign inv_phase = 9'd256 - {1'b0, phase};
   assign inv_xf    = 9'd256 - {1'b0, xf2_ff};
   assign inv_yf    = 9'd256 - {1'b0, yf3_ff};

   always_comb begin
      for (int q = 0; q < 4; q++) begin
         m_in[q] = 8'((17'(rd_data[0][q]) * 17'(inv_phase)
                     + 17'(rd_data[1][q]) * 17'(phase)) >> 8);
      end
      top_in = 17'(m_ff[0]) * 17'(inv_xf) + 17'(m_ff[1]) * 17'(xf2_ff);
      bot_in = 17'(m_ff[2]) * 17'(inv_xf) + 17'(m_ff[3]) * 17'(xf2_ff);
      mix_in = 25'(top_ff) * 25'(inv_yf) + 25'(bot_ff) * 25'(yf3_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         xf1_ff <= cvn_pkg::EASE_ROM[xe];
         yf1_ff <= cvn_pkg::EASE_ROM[ye];
      end
      if (en.s2) begin
         xf2_ff <= xf1_ff;
         yf2_ff <= yf1_ff;
         m_ff   <= m_in;
      end
      if (en.s3) begin
         yf3_ff <= yf2_ff;
         top_ff <= top_in[15:0];
         bot_ff <= bot_in[15:0];
      end
      if (en.s4) begin
         lv_ff <= mix_in[23:16] >> K;
      end
   end

   assign level_val = lv_ff;
endmodule

// File: sv/cloud_value_noise_pixel.sv
// ----------------------------------------------------------------------------
// Cloud value noise pixel
// Octave value noise with cosine easing, thresholded to a cloud alpha byte.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                         beat
//   req_chan  in    func bank level entry_index entry_value         write or pixel
//                   pixel_x pixel_y mask_alpha
//   rsp_chan  out   alpha_out out_x out_y                           one per pixel
//   csr_*     in    csr_we csr_index csr_wdata                      register write
//
// The pipeline takes one beat every cycle unless it is full and the output stalls.
// A pixel passes through the map RAM read, three multiply stages, the
// threshold sum, four radix-4 divider stages and the mask scale.
// Reset is synchronous and clears the valid bits and the configuration registers;
// map contents are not cleared and hold nothing defined until the host writes them.
// Each stage holds when the stage after it is full and stalled, so bubbles close
// up and, while some stage is free, a new beat is taken as a result waits at the output.
//
module cloud_value_noise_pixel #(
   parameter int LEVELS = 5
) (
   input  logic       clock,
   input  logic       reset,
   cvn_req_if.sink    req_chan,
   cvn_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [8:0] csr_wdata
);
`include "cloud_value_noise_pixel_assert.svh"

   // Stage numbers.
   localparam int ST_THR  = 5;
   localparam int ST_DIV  = 6;
   localparam int DIV_STG = 4;
   localparam int ST_MUL  = ST_DIV + DIV_STG;
   localparam int NST     = ST_MUL + 1;

   logic [8:0] coverage_ff;
   logic [7:0] phase_ff;

   logic [NST:1] vld_ff;
   logic [NST:1] en;
   cvn_pkg::pix_type pix_ff [1:NST];
   cvn_pkg::pix_type pix_in;

   logic pixel_acc;
   logic write_acc;
   cvn_pkg::lvl_en_type lvl_en;
   logic [7:0] lvl_val [LEVELS];

   logic [9:0] lvl_sum;
   logic [7:0] sum_clamp;
   logic [8:0] cov_eff;
   logic [8:0] inv_cov;
   logic [7:0] thr_in;
   logic [7:0] thr_ff;

   logic [8:0] div_r_ff [DIV_STG];
   logic [7:0] div_q_ff [DIV_STG];
   logic [8:0] div_r_in [DIV_STG];
   logic [7:0] div_q_in [DIV_STG];
   logic [8:0] r_work;
   logic [7:0] q_work;
   logic [9:0] r_dbl;

   logic [15:0] prod_ff;
   logic [16:0] scale_sum;
   logic [7:0]  alpha_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coverage_ff <= cvn_pkg::COVERAGE_RESET;
         phase_ff    <= cvn_pkg::PHASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cvn_pkg::CSR_COVERAGE: coverage_ff <= csr_wdata;
            cvn_pkg::CSR_PHASE:    phase_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its own content moves on.
   always_comb begin
      en[NST] = !vld_ff[NST] || rsp_chan.ready;
      for (int i = NST - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i + 1];
      end
   end

   assign req_chan.ready = en[1];
   assign pixel_acc = req_chan.valid && en[1] && (req_chan.func == cvn_pkg::FUNC_PIXEL);
   assign write_acc = req_chan.valid && en[1] && (req_chan.func == cvn_pkg::FUNC_WRITE);

   assign pix_in.x    = req_chan.pixel_x;
   assign pix_in.y    = req_chan.pixel_y;
   assign pix_in.mask = req_chan.mask_alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= pixel_acc;
         end
         for (int i = 2; i <= NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pix_ff[1] <= pix_in;
      end
      for (int i = 2; i <= NST; i++) begin
         if (en[i]) begin
            pix_ff[i] <= pix_ff[i - 1];
         end
      end
   end

   // Stages one to four: per-level map read, bank blend and interpolation.
   assign lvl_en.s1 = en[1];
   assign lvl_en.s2 = en[2];
   assign lvl_en.s3 = en[3];
   assign lvl_en.s4 = en[4];

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      cvn_level #(.LEVELS(LEVELS), .K(k)) u_level (
         .clock     (clock),
         .en        (lvl_en),
         .phase     (phase_ff),
         .wr_en     (write_acc),
         .wr_bank   (req_chan.bank),
         .wr_level  (req_chan.level),
         .wr_index  (req_chan.entry_index),
         .wr_value  (req_chan.entry_value),
         .pix_x     (req_chan.pixel_x),
         .pix_y     (req_chan.pixel_y),
         .level_val (lvl_val[k])
      );
   end

   // Stage five: octave sum, clamp and coverage threshold. A coverage of zero
   // behaves as one, and anything above 256 behaves as 256.
   always_comb begin
      lvl_sum = '0;
      for (int k = 0; k < LEVELS; k++) begin
         lvl_sum = lvl_sum + 10'(lvl_val[k]);
      end
      sum_clamp = (lvl_sum > 10'd255) ? 8'd255 : lvl_sum[7:0];
      if (coverage_ff == 9'd0) begin
         cov_eff = 9'd1;
      end else if (coverage_ff > 9'd256) begin
         cov_eff = 9'd256;
      end else begin
         cov_eff = coverage_ff;
      end
      inv_cov = 9'd256 - cov_eff;
      thr_in  = ({1'b0, sum_clamp} < inv_cov) ? 8'd0 : 8'({1'b0, sum_clamp} - inv_cov);
   end

   always_ff @(posedge clock) begin
      if (en[ST_THR]) begin
         thr_ff <= thr_in;
      end
   end

   // Stages six to nine: restoring division of v*256 by the coverage, two
   // quotient bits per stage. The threshold keeps v below the coverage, so
   // the quotient fits eight bits and the partial remainder stays below it.
   always_comb begin
      r_work = '0;
      q_work = '0;
      r_dbl  = '0;
      for (int s = 0; s < DIV_STG; s++) begin
         r_work = (s == 0) ? {1'b0, thr_ff} : div_r_ff[(s > 0) ? s - 1 : 0];
         q_work = (s == 0) ? 8'd0 : div_q_ff[(s > 0) ? s - 1 : 0];
         for (int j = 0; j < 2; j++) begin
            r_dbl = {r_work, 1'b0};
            if (r_dbl >= {1'b0, cov_eff}) begin
               r_work = 9'(r_dbl - {1'b0, cov_eff});
               q_work = {q_work[6:0], 1'b1};
            end else begin
               r_work = r_dbl[8:0];
               q_work = {q_work[6:0], 1'b0};
            end
         end
         div_r_in[s] = r_work;
         div_q_in[s] = q_work;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STG; s++) begin
         if (en[ST_DIV + s]) begin
            div_r_ff[s] <= div_r_in[s];
            div_q_ff[s] <= div_q_in[s];
         end
      end
   end

   // Stage ten multiplies the inverted quotient by the mask; the output stage
   // divides by 255 with the exact 16-bit reciprocal form.
   assign scale_sum = 17'(prod_ff) + 17'(prod_ff >> 8) + 17'd1;

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         prod_ff <= 16'(8'd255 - div_q_ff[DIV_STG - 1]) * 16'(pix_ff[ST_MUL - 1].mask);
      end
      if (en[NST]) begin
         alpha_ff <= scale_sum[15:8];
      end
   end

   assign rsp_chan.valid     = vld_ff[NST];
   assign rsp_chan.alpha_out = alpha_ff;
   assign rsp_chan.out_x     = pix_ff[NST].x;
   assign rsp_chan.out_y     = pix_ff[NST].y;

   // A refused beat means every stage is full.
   `CVN_ASSERT_IMPLY(a_ready_full, !req_chan.ready, &vld_ff,
      "input refused while the pipeline has a free stage")
   // A map write never creates a pipeline item.
   `CVN_ASSERT_NEXT(a_write_no_item, write_acc, !vld_ff[1],
      "map write entered the pixel pipeline")
   // The threshold result stays below the coverage divisor.
   `CVN_ASSERT_IMPLY(a_thr_range, vld_ff[ST_THR], {1'b0, thr_ff} < cov_eff,
      "threshold value not below coverage")
   // The final partial remainder stays below the divisor.
   `CVN_ASSERT_IMPLY(a_div_rem, vld_ff[ST_MUL - 1], div_r_ff[DIV_STG - 1] < cov_eff,
      "divider remainder out of range")
endmodule
